// ----- src/adb_pkg.sv -----
// Shared types, constants and tables for the ADPCM block decoder.
`default_nettype none
package adb_pkg;

   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int MAX_COEF_SETS   = 7;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int QPTR_W          = $clog2(CMD_QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE = 3'd0;

   localparam logic [3:0] MONO_LAST_POS   = 4'd6;
   localparam logic [3:0] STEREO_LAST_POS = 4'd13;

   localparam logic [31:0] COEF_RESET [MAX_COEF_SETS] = '{
      32'd16777216, 32'd33619712, 32'd0, 32'd12582976,
      32'd15728640, 32'd30211888, 32'd25755416
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel;
      logic               last;
      logic               bad_predictor;
   } rsp_type;

   typedef enum logic [0:0] {
      CMD_HEADER = 1'b0,
      CMD_DATA   = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   pos;
      logic         stereo;
      logic         complete;
      logic [7:0]   data_byte;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [9:0] adapt_gain(input logic [3:0] code);
      logic [9:0] g;
      case (code)
         4'd4, 4'd12: g = 10'd307;
         4'd5, 4'd11: g = 10'd409;
         4'd6, 4'd10: g = 10'd512;
         4'd7, 4'd9:  g = 10'd614;
         4'd8:        g = 10'd768;
         default:     g = 10'd230;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// ----- src/adb_front.sv -----
// Front end: accepts block bytes, tracks header position, emits commands.
`default_nettype none
module adb_front
   import adb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             stereo_mode,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic       in_header_ff, in_header_in;
   logic [3:0] hdr_pos_ff, hdr_pos_in;
   logic       hdr_active;
   logic [3:0] pos;

   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      in_header_in = in_header_ff;
      hdr_pos_in   = hdr_pos_ff;
      hdr_active   = in_header_ff || req_data.block_start;
      pos          = req_data.block_start ? 4'd0 : hdr_pos_ff;
      if (!stereo_mode && pos > MONO_LAST_POS) begin
         pos = MONO_LAST_POS;
      end
      q_cmd.kind      = hdr_active ? CMD_HEADER : CMD_DATA;
      q_cmd.pos       = pos;
      q_cmd.stereo    = stereo_mode;
      q_cmd.complete  = stereo_mode ? (pos >= STEREO_LAST_POS) : (pos == MONO_LAST_POS);
      q_cmd.data_byte = req_data.data_byte;
      if (q_push && hdr_active) begin
         in_header_in = !q_cmd.complete;
         hdr_pos_in   = q_cmd.complete ? 4'd0 : pos + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff <= 1'b1;
         hdr_pos_ff   <= 4'd0;
      end else begin
         in_header_ff <= in_header_in;
         hdr_pos_ff   <= hdr_pos_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/adb_cmd_queue.sv -----
// Short command queue between the front end and the decode engine.
`default_nettype none
module adb_cmd_queue
   import adb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output queue_status_type status
);

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(CMD_QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(CMD_QUEUE_DEPTH);

   cmd_type             slot_ff [CMD_QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/adb_back.sv -----
// Decode engine: header field loads, nibble prediction and delta adaptation.
`default_nettype none
module adb_back
   import adb_pkg::*;
#(
   parameter int COEF_SETS = 7
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic [31:0] coef_set [COEF_SETS],
   input  wire cmd_type q_cmd,
   input  wire queue_status_type q_status,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (COEF_SETS > 1) ? $clog2(COEF_SETS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_HDR  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic               nib_ff, nib_in;
   logic [1:0]         hdr_k_ff, hdr_k_in;
   logic [7:0]         hold_ff, hold_in;
   logic signed [15:0] c1_ff [2], c1_in [2];
   logic signed [15:0] c2_ff [2], c2_in [2];
   logic signed [15:0] delta_ff [2], delta_in [2];
   logic signed [15:0] s1_ff [2], s1_in [2];
   logic signed [15:0] s2_ff [2], s2_in [2];
   logic               bad_ff [2], bad_in [2];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [31:0] m1_ff, m2_ff;
   logic signed [19:0] cd_ff;
   logic signed [26:0] dg_ff;

   logic               ch, slot_free, pred_ch, pred_bad, hch;
   logic [3:0]         nibble;
   logic signed [3:0]  code;
   logic signed [15:0] word, pred_c1, pred_c2, new_sample, new_delta;
   logic [31:0]        pred_pair;
   logic signed [32:0] psum;
   logic signed [24:0] pshift;
   logic signed [25:0] pfull;
   logic signed [18:0] dshift;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ch        = cmd_ff.stereo ? nib_ff : 1'b0;
   assign nibble    = nib_ff ? cmd_ff.data_byte[3:0] : cmd_ff.data_byte[7:4];
   assign code      = signed'(nibble);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign word      = signed'({q_cmd.data_byte, hold_ff});
   assign pred_bad  = (q_cmd.data_byte >= 8'(COEF_SETS));
   assign pred_pair = coef_set[q_cmd.data_byte[IDX_W-1:0]];
   assign pred_c1   = pred_bad ? 16'sd0 : signed'(pred_pair[31:16]);
   assign pred_c2   = pred_bad ? 16'sd0 : signed'(pred_pair[15:0]);
   assign pred_ch   = q_cmd.stereo ? q_cmd.pos[0] : 1'b0;

   assign psum   = m1_ff + m2_ff;
   assign pshift = psum[32:8];
   assign pfull  = pshift + cd_ff;
   assign dshift = dg_ff[26:8];

   always_comb begin
      if (pfull > 26'sd32767) begin
         new_sample = 16'sh7FFF;
      end else if (pfull < -26'sd32768) begin
         new_sample = -16'sh8000;
      end else begin
         new_sample = pfull[15:0];
      end
      if (dshift < 19'sd16) begin
         new_delta = 16'sd16;
      end else if (dshift > 19'sd32767) begin
         new_delta = 16'sh7FFF;
      end else begin
         new_delta = dshift[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         m1_ff <= s1_ff[ch] * c1_ff[ch];
         m2_ff <= s2_ff[ch] * c2_ff[ch];
         cd_ff <= code * delta_ff[ch];
         dg_ff <= delta_ff[ch] * signed'({1'b0, adapt_gain(nibble)});
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      nib_in       = nib_ff;
      hdr_k_in     = hdr_k_ff;
      hold_in      = hold_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      delta_in     = delta_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      hch          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.kind == CMD_DATA) begin
                  nib_in   = 1'b0;
                  state_in = ST_MUL;
               end else begin
                  if (q_cmd.stereo) begin
                     case (q_cmd.pos)
                        4'd0, 4'd1: begin
                           bad_in[pred_ch] = pred_bad;
                           c1_in[pred_ch]  = pred_c1;
                           c2_in[pred_ch]  = pred_c2;
                        end
                        4'd3:    delta_in[0] = word;
                        4'd5:    delta_in[1] = word;
                        4'd7:    s1_in[0]    = word;
                        4'd9:    s1_in[1]    = word;
                        4'd11:   s2_in[0]    = word;
                        4'd13:   s2_in[1]    = word;
                        default: hold_in     = q_cmd.data_byte;
                     endcase
                  end else begin
                     case (q_cmd.pos)
                        4'd0: begin
                           bad_in[0] = pred_bad;
                           c1_in[0]  = pred_c1;
                           c2_in[0]  = pred_c2;
                        end
                        4'd2:    delta_in[0] = word;
                        4'd4:    s1_in[0]    = word;
                        4'd6:    s2_in[0]    = word;
                        default: hold_in     = q_cmd.data_byte;
                     endcase
                  end
                  if (q_cmd.complete) begin
                     hdr_k_in = 2'd0;
                     state_in = ST_HDR;
                  end
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (slot_free) begin
               delta_in[ch]              = new_delta;
               s2_in[ch]                 = s1_ff[ch];
               s1_in[ch]                 = new_sample;
               rsp_valid_in              = 1'b1;
               rsp_data_in.sample        = new_sample;
               rsp_data_in.channel       = ch;
               rsp_data_in.last          = nib_ff;
               rsp_data_in.bad_predictor = bad_ff[ch];
               if (nib_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  nib_in   = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_HDR: begin
            if (slot_free) begin
               // stereo: s2 left, s2 right, s1 left, s1 right; mono: s2, s1
               hch                       = cmd_ff.stereo ? hdr_k_ff[0] : 1'b0;
               rsp_valid_in              = 1'b1;
               rsp_data_in.channel       = hch;
               rsp_data_in.bad_predictor = bad_ff[hch];
               if (cmd_ff.stereo) begin
                  rsp_data_in.sample = hdr_k_ff[1] ? s1_ff[hch] : s2_ff[hch];
                  rsp_data_in.last   = (hdr_k_ff == 2'd3);
               end else begin
                  rsp_data_in.sample = hdr_k_ff[0] ? s1_ff[0] : s2_ff[0];
                  rsp_data_in.last   = (hdr_k_ff == 2'd1);
               end
               hdr_k_in = hdr_k_ff + 2'd1;
               if (rsp_data_in.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      nib_ff      <= nib_in;
      hdr_k_ff    <= hdr_k_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= 8'd0;
         for (int i = 0; i < 2; i++) begin
            c1_ff[i]    <= 16'sd0;
            c2_ff[i]    <= 16'sd0;
            delta_ff[i] <= 16'sd16;
            s1_ff[i]    <= 16'sd0;
            s2_ff[i]    <= 16'sd0;
            bad_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         c1_ff        <= c1_in;
         c2_ff        <= c2_in;
         delta_ff     <= delta_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         bad_ff       <= bad_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/ms_adpcm_block_decoder.sv -----
// Top level of the ADPCM block decoder: control registers and the three stages.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_ready  req_data (data_byte, block_start)
//   rsp_*        out         rsp_valid/rsp_ready  rsp_data (sample, channel, last, flag)
//   csr_*        in          csr_we               csr_index, csr_wdata
//
// Header bytes are loaded by the decode engine as each one is popped; the completing byte
// then emits two (mono) or four (stereo) results, one per cycle while the output is free.
// A data byte is popped, then each of its nibbles passes a multiply state and
// an accumulate/clamp state, which waits for the output register to be free.
// Synchronous reset; no clearing pass. The front end keeps taking bytes into
// a two-entry queue while the engine or the output register is stalled.
`default_nettype none
module ms_adpcm_block_decoder
   import adb_pkg::*;
#(
   parameter int COEF_SETS = 7
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic             stereo_ff;
   logic [31:0]      coef_ff [COEF_SETS];
   logic             q_push, q_pop;
   cmd_type          push_cmd, head_cmd;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         for (int k = 0; k < COEF_SETS; k++) begin
            coef_ff[k] <= COEF_RESET[k];
         end
      end else if (csr_we) begin
         if (csr_index == CSR_STEREO_MODE) begin
            stereo_ff <= csr_wdata[0];
         end
         for (int k = 0; k < COEF_SETS; k++) begin
            if (csr_index == CSR_IDX_W'(k + 1)) begin
               coef_ff[k] <= csr_wdata;
            end
         end
      end
   end

   adb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .stereo_mode (stereo_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   adb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   adb_back #(
      .COEF_SETS (COEF_SETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .coef_set  (coef_ff),
      .q_cmd     (head_cmd),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("command queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("command queue read while empty");

   a_transfer_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> q_push)
      else $error("input transfer not queued");
`endif

endmodule
`default_nettype wire

// ----- dv/ms_adpcm_block_decoder_tb.sv -----
// Self-checking testbench for the ADPCM block decoder: random byte streams against a local predictor.
module ms_adpcm_block_decoder_tb;
   import adb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BASE = 3'd1;
   localparam logic                 CH_LEFT       = 1'b0;
   localparam logic                 CH_RIGHT      = 1'b1;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE       = 24;
   localparam int PHASE_BYTES  = 75;
   localparam int ADAPT_STEP [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                                      768, 614, 512, 409, 307, 230, 230, 230};
   localparam logic [31:0] EXTREME_SET [MAX_COEF_SETS] = '{
      32'h7FFF7FFF, 32'h80008000, 32'hFFFFFFFF, 32'h00000000,
      32'h7FFF8000, 32'h80007FFF, 32'h01000000
   };

   typedef enum {COEFS_DEFAULT, COEFS_EXTREME, COEFS_WILD, COEFS_AUDIO} coef_plan_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ms_adpcm_block_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder state as predicted
   logic               mdl_stereo;
   logic [31:0]        mdl_coef [MAX_COEF_SETS];
   logic [3:0]         hdr_pos;
   logic               in_hdr;
   logic [7:0]         lo_hold;
   logic signed [15:0] ch_c1 [2];
   logic signed [15:0] ch_c2 [2];
   logic signed [15:0] ch_delta [2];
   logic signed [15:0] ch_s1 [2];
   logic signed [15:0] ch_s2 [2];
   logic               ch_bad [2];

   req_type byte_queue [$];
   rsp_type pcm_due [$];
   int      send_idle_pct = 9;
   int      recv_idle_pct = 73;
   int      stall_cycles = 0;
   int      errors = 0;
   int      bytes_in = 0;
   int      samples_out = 0;
   int      settings = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void load_set(input logic ch, input logic [7:0] idx);
      if (idx >= MAX_COEF_SETS) begin
         ch_bad[ch] = 1'b1;
         ch_c1[ch]  = '0;
         ch_c2[ch]  = '0;
      end else begin
         ch_bad[ch] = 1'b0;
         ch_c1[ch]  = mdl_coef[idx][31:16];
         ch_c2[ch]  = mdl_coef[idx][15:0];
      end
   endfunction

   function automatic logic signed [15:0] next_sample(input logic ch, input logic [3:0] code);
      longint acc;
      longint nd;
      acc = (longint'(ch_s1[ch]) * longint'(ch_c1[ch])
             + longint'(ch_s2[ch]) * longint'(ch_c2[ch])) >>> 8;
      acc = acc + longint'($signed(code)) * longint'(ch_delta[ch]);
      nd = (longint'(ch_delta[ch]) * longint'(ADAPT_STEP[code])) >>> 8;
      if (nd < 16) nd = 16;
      if (nd > 32767) nd = 32767;
      ch_delta[ch] = 16'(nd);
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      ch_s2[ch] = ch_s1[ch];
      ch_s1[ch] = 16'(acc);
      return ch_s1[ch];
   endfunction

   function automatic void queue_pcm(input logic signed [15:0] s, input logic ch,
                                     input logic last);
      rsp_type e;
      e.sample        = s;
      e.channel       = ch;
      e.last          = last;
      e.bad_predictor = ch_bad[ch];
      pcm_due.push_back(e);
   endfunction

   function automatic void decode_byte(input req_type r);
      logic [3:0]         pos;
      logic signed [15:0] word;
      if (r.block_start) begin
         in_hdr  = 1'b1;
         hdr_pos = '0;
      end
      if (!in_hdr) begin
         queue_pcm(next_sample(CH_LEFT, r.data_byte[7:4]), CH_LEFT, 1'b0);
         if (mdl_stereo)
            queue_pcm(next_sample(CH_RIGHT, r.data_byte[3:0]), CH_RIGHT, 1'b1);
         else
            queue_pcm(next_sample(CH_LEFT, r.data_byte[3:0]), CH_LEFT, 1'b1);
         return;
      end
      pos  = hdr_pos;
      word = {r.data_byte, lo_hold};
      if (!mdl_stereo) begin
         if (pos > MONO_LAST_POS) pos = MONO_LAST_POS;
         case (pos)
            4'd0: load_set(CH_LEFT, r.data_byte);
            4'd2: ch_delta[CH_LEFT] = word;
            4'd4: ch_s1[CH_LEFT] = word;
            4'd6: ch_s2[CH_LEFT] = word;
            default: lo_hold = r.data_byte;
         endcase
         if (pos == MONO_LAST_POS) begin
            in_hdr  = 1'b0;
            hdr_pos = '0;
            queue_pcm(ch_s2[CH_LEFT], CH_LEFT, 1'b0);
            queue_pcm(ch_s1[CH_LEFT], CH_LEFT, 1'b1);
            return;
         end
      end else begin
         case (pos)
            4'd0:  load_set(CH_LEFT, r.data_byte);
            4'd1:  load_set(CH_RIGHT, r.data_byte);
            4'd3:  ch_delta[CH_LEFT] = word;
            4'd5:  ch_delta[CH_RIGHT] = word;
            4'd7:  ch_s1[CH_LEFT] = word;
            4'd9:  ch_s1[CH_RIGHT] = word;
            4'd11: ch_s2[CH_LEFT] = word;
            4'd13: ch_s2[CH_RIGHT] = word;
            default: lo_hold = r.data_byte;
         endcase
         if (pos >= STEREO_LAST_POS) begin
            in_hdr  = 1'b0;
            hdr_pos = '0;
            queue_pcm(ch_s2[CH_LEFT], CH_LEFT, 1'b0);
            queue_pcm(ch_s2[CH_RIGHT], CH_RIGHT, 1'b0);
            queue_pcm(ch_s1[CH_LEFT], CH_LEFT, 1'b0);
            queue_pcm(ch_s1[CH_RIGHT], CH_RIGHT, 1'b1);
            return;
         end
      end
      hdr_pos = pos + 4'd1;
   endfunction

   // byte feeder
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data);
            bytes_in++;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // sample checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         samples_out++;
         if (pcm_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected sample transfer, got sample %0d channel %0b",
                     $time, $signed(rsp_data.sample), rsp_data.channel);
         end else begin
            e = pcm_due.pop_front();
            if (rsp_data.sample !== e.sample) begin
               errors++;
               $display("%0t: sample expected %0d got %0d", $time,
                        $signed(e.sample), $signed(rsp_data.sample));
            end
            if (rsp_data.channel !== e.channel) begin
               errors++;
               $display("%0t: channel expected %0b got %0b", $time, e.channel,
                        rsp_data.channel);
            end
            if (rsp_data.last !== e.last) begin
               errors++;
               $display("%0t: last expected %0b got %0b", $time, e.last, rsp_data.last);
            end
            if (rsp_data.bad_predictor !== e.bad_predictor) begin
               errors++;
               $display("%0t: bad_predictor expected %0b got %0b", $time,
                        e.bad_predictor, rsp_data.bad_predictor);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("[ms_adpcm_block_decoder] ERROR");
      $finish;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STEREO_MODE)
         mdl_stereo = val[0];
      else
         mdl_coef[idx - CSR_COEF_BASE] = val;
   endtask

   task automatic configure(input logic st, input coef_plan_type plan);
      logic [31:0] v;
      write_csr(CSR_STEREO_MODE, {31'b0, st});
      for (int k = 0; k < MAX_COEF_SETS; k++) begin
         case (plan)
            COEFS_DEFAULT: v = COEF_RESET[k];
            COEFS_EXTREME: v = EXTREME_SET[k];
            COEFS_WILD:    v = $urandom;
            default:       v = {16'($urandom_range(1279)) - 16'd512,
                                16'($urandom_range(1023)) - 16'd512};
         endcase
         write_csr(CSR_IDX_W'(CSR_COEF_BASE + k), v);
      end
      settings++;
   endtask

   // stop feeding until the decoder has nothing left to emit
   task automatic wait_idle();
      while (byte_queue.size() > 0 || req_valid || pcm_due.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b, input logic s);
      req_type r;
      r.data_byte   = b;
      r.block_start = s;
      byte_queue.push_back(r);
   endtask

   task automatic push_header(input logic st, input logic first_start,
                              input logic [7:0] idx0, input logic [7:0] idx1,
                              input logic [15:0] dl0, input logic [15:0] dl1,
                              input logic [15:0] sa0, input logic [15:0] sa1,
                              input logic [15:0] sb0, input logic [15:0] sb1,
                              input int count);
      logic [15:0] words [6];
      logic [7:0]  seq [$];
      seq.push_back(idx0);
      if (st) seq.push_back(idx1);
      words = '{dl0, dl1, sa0, sa1, sb0, sb1};
      for (int w = 0; w < 6; w++) begin
         if (st || w % 2 == 0) begin
            seq.push_back(words[w][7:0]);
            seq.push_back(words[w][15:8]);
         end
      end
      for (int i = 0; i < count && i < seq.size(); i++)
         push_byte(seq[i], (i == 0) ? first_start : 1'b0);
   endtask

   function automatic logic [7:0] pick_idx();
      return ($urandom_range(99) < 80) ? 8'($urandom_range(6)) : 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_delta();
      return ($urandom_range(99) < 70) ? 16'($urandom_range(16, 2047)) : 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_sample();
      return ($urandom_range(1) == 0) ? 16'($urandom)
                                      : 16'($urandom_range(2000)) - 16'd1000;
   endfunction

   task automatic push_random_block(input logic st, inout int count);
      int kind;
      int len;
      int n;
      kind = $urandom_range(99);
      len  = st ? 14 : 7;
      if (kind < 85) begin
         n = $urandom_range(1, 10);
         push_header(st, 1'b1, pick_idx(), pick_idx(), pick_delta(), pick_delta(),
                     pick_sample(), pick_sample(), pick_sample(), pick_sample(), len);
         repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
         count += len + n;
      end else if (kind < 93) begin
         n = $urandom_range(1, len - 1);
         push_header(st, 1'b1, pick_idx(), pick_idx(), pick_delta(), pick_delta(),
                     pick_sample(), pick_sample(), pick_sample(), pick_sample(), n);
         count += n;
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
         count += n;
      end
   endtask

   initial begin
      coef_plan_type plans [6];
      int            count;
      bit            paused;
      mdl_stereo = 1'b0;
      for (int k = 0; k < MAX_COEF_SETS; k++) mdl_coef[k] = COEF_RESET[k];
      hdr_pos = '0;
      in_hdr  = 1'b1;
      lo_hold = '0;
      for (int c = 0; c < 2; c++) begin
         ch_c1[c]    = '0;
         ch_c2[c]    = '0;
         ch_delta[c] = 16'sd16;
         ch_s1[c]    = '0;
         ch_s2[c]    = '0;
         ch_bad[c]   = 1'b0;
      end
      plans = '{COEFS_DEFAULT, COEFS_EXTREME, COEFS_WILD, COEFS_AUDIO, COEFS_AUDIO, COEFS_WILD};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // mono, reset values: header without a block start, block start during data
      // and during a header, bad predictor indexes, negative header delta
      push_header(1'b0, 1'b0, 8'd3, 8'd0, 16'd16, 16'd0, 16'h7FFF, 16'd0,
                  16'h8000, 16'd0, 7);
      push_byte(8'h08, 1'b0);
      push_byte(8'hF7, 1'b0);
      push_header(1'b0, 1'b1, 8'hFF, 8'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 3);
      push_header(1'b0, 1'b1, 8'd7, 8'd0, 16'h8000, 16'd0, 16'h8000, 16'd0,
                  16'h7FFF, 16'd0, 7);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h00, 1'b0);
      wait_idle();

      // stereo header cut short by a switch to mono
      write_csr(CSR_STEREO_MODE, 32'd1);
      push_header(1'b1, 1'b1, 8'd1, 8'd9, 16'd300, 16'hFFF0, 16'd1234, 16'hABCD,
                  16'h5555, 16'hAAAA, 9);
      wait_idle();
      write_csr(CSR_STEREO_MODE, 32'd0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b0);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 9 : (p < 4) ? 73 : 0;
         recv_idle_pct = (p < 2) ? 73 : (p < 4) ? 9 : 0;
         configure(p % 2 == 1, plans[p]);
         count  = 0;
         paused = 1'b0;
         while (count < PHASE_BYTES) begin
            push_random_block(p % 2 == 1, count);
            if (!paused && count >= PHASE_BYTES / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
         wait_idle();
      end

      $display("Fed %0d bytes and checked %0d samples over %0d register settings,",
               bytes_in, samples_out, settings);
      $display("mono and stereo, default, extreme and random coefficient sets.");
      if (errors == 0)
         $display("[ms_adpcm_block_decoder] OK");
      else
         $display("[ms_adpcm_block_decoder] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
src/adb_pkg.sv
src/adb_front.sv
src/adb_cmd_queue.sv
src/adb_back.sv
src/ms_adpcm_block_decoder.sv
dv/ms_adpcm_block_decoder_tb.sv
